@@ rtl/rate_group_client_table_core_assert.svh @@
`ifndef RATE_GROUP_CLIENT_TABLE_CORE_ASSERT_SVH
`define RATE_GROUP_CLIENT_TABLE_CORE_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define RGCT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked on every rising edge out of reset
`define RGCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/rgct_pkg.sv @@
package rgct_pkg;

    localparam int SLOTS_PER_GROUP = 16;
    localparam int GROUP_COUNT     = 3;
    localparam int ID_W            = 16;
    localparam int GROUP_W         = 2;
    localparam int SLOT_W          = $clog2(SLOTS_PER_GROUP);
    localparam int CNT_W           = $clog2(SLOTS_PER_GROUP + 1);
    localparam int MEM_DEPTH       = GROUP_COUNT * SLOTS_PER_GROUP;
    localparam int ADDR_W          = $clog2(MEM_DEPTH);

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_ADD,
        OP_FIRST,
        OP_NEXT
    } rgct_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } rgct_state_t;

endpackage

@@ rtl/rgct_if.sv @@
interface rgct_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  opcode;
    logic [rgct_pkg::GROUP_W-1:0] rate_group;
    logic [rgct_pkg::ID_W-1:0]   client_id;

    modport source (output valid, output opcode, output rate_group, output client_id,
                    input ready);
    modport sink   (input valid, input opcode, input rate_group, input client_id,
                    output ready);
endinterface

interface rgct_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      status;
    logic                      entry_present;
    logic [rgct_pkg::ID_W-1:0] entry_id;
    logic                      end_of_list;

    modport source (output valid, output status, output entry_present, output entry_id,
                    output end_of_list, input ready);
    modport sink   (input valid, input status, input entry_present, input entry_id,
                    input end_of_list, output ready);
endinterface

@@ rtl/rgct_ram.sv @@
module rgct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rate_group_client_table_core.sv @@
// a request's result is registered in the slot RAM read and pending flags, then in the output register
// one transaction in flight: a new request is taken only once the previous result has moved into the output register
// slots fill in order, so a per-group fill count stands in for per-slot valid bits
// clear-all takes effect by zeroing the fill counts and cursors of all groups
// reset: asynchronous, clears fill counts, cursors, state and output valid; no clearing pass
module rate_group_client_table_core (
    input  logic       clk,
    input  logic       rst_n,
    rgct_req_if.sink   req,
    rgct_rsp_if.source rsp
);

    localparam int SLOTS  = rgct_pkg::SLOTS_PER_GROUP;
    localparam int GROUPS = rgct_pkg::GROUP_COUNT;
    localparam int SLOT_W = rgct_pkg::SLOT_W;
    localparam int CNT_W  = rgct_pkg::CNT_W;
    localparam int ADDR_W = rgct_pkg::ADDR_W;
    localparam int ID_W   = rgct_pkg::ID_W;

    rgct_pkg::rgct_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg  [GROUPS];
    logic [CNT_W-1:0]  cnt_next [GROUPS];
    logic [SLOT_W-1:0] cur_reg  [GROUPS];
    logic [SLOT_W-1:0] cur_next [GROUPS];

    logic pend_status_reg, pend_status_next;
    logic pend_present_reg, pend_present_next;
    logic pend_eol_reg, pend_eol_next;

    logic            out_valid_reg, out_valid_next;
    logic            out_status_reg, out_status_next;
    logic            out_present_reg, out_present_next;
    logic [ID_W-1:0] out_id_reg, out_id_next;
    logic            out_eol_reg, out_eol_next;

    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ID_W-1:0]   mem_rdata;

    logic                         req_fire;
    logic                         grp_ok;
    logic [rgct_pkg::GROUP_W-1:0] gsel;
    logic [CNT_W-1:0]             fill;
    logic [SLOT_W-1:0]            cur;
    logic [SLOT_W-1:0]            pos;
    logic [ADDR_W-1:0]            base;

    rgct_ram #(
        .WIDTH (ID_W),
        .DEPTH (rgct_pkg::MEM_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.client_id),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready         = (state_reg == rgct_pkg::ST_IDLE);
    assign req_fire          = req.valid && req.ready;
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.entry_present = out_present_reg;
    assign rsp.entry_id      = out_id_reg;
    assign rsp.end_of_list   = out_eol_reg;

    assign gsel   = req.rate_group;
    assign grp_ok = (gsel < rgct_pkg::GROUP_W'(GROUPS));
    assign fill   = grp_ok ? cnt_reg[gsel] : '0;
    assign cur    = grp_ok ? cur_reg[gsel] : '0;
    assign pos    = cur + SLOT_W'(1);
    assign base   = ADDR_W'(gsel) * ADDR_W'(SLOTS);

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        cur_next          = cur_reg;
        pend_status_next  = pend_status_reg;
        pend_present_next = pend_present_reg;
        pend_eol_next     = pend_eol_reg;
        out_valid_next    = out_valid_reg;
        out_status_next   = out_status_reg;
        out_present_next  = out_present_reg;
        out_id_next       = out_id_reg;
        out_eol_next      = out_eol_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = base + ADDR_W'(fill[SLOT_W-1:0]);
        mem_raddr         = base;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            rgct_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next        = rgct_pkg::ST_RESP;
                    pend_status_next  = 1'b0;
                    pend_present_next = 1'b0;
                    pend_eol_next     = 1'b0;
                    unique case (rgct_pkg::rgct_op_t'(req.opcode))
                        rgct_pkg::OP_CLEAR:
                        begin
                            for (int g = 0; g < GROUPS; g++)
                            begin
                                cnt_next[g] = '0;
                                cur_next[g] = '0;
                            end
                        end
                        rgct_pkg::OP_ADD:
                        begin
                            if (grp_ok)
                            begin
                                if (fill == CNT_W'(SLOTS))
                                begin
                                    pend_status_next = 1'b1;
                                end
                                else
                                begin
                                    mem_we         = 1'b1;
                                    cnt_next[gsel] = fill + CNT_W'(1);
                                end
                            end
                        end
                        rgct_pkg::OP_FIRST:
                        begin
                            if (grp_ok)
                            begin
                                cur_next[gsel]    = '0;
                                mem_re            = 1'b1;
                                mem_raddr         = base;
                                pend_present_next = (fill != '0);
                            end
                        end
                        rgct_pkg::OP_NEXT:
                        begin
                            if (grp_ok)
                            begin
                                if (cur == SLOT_W'(SLOTS - 1))
                                begin
                                    cur_next[gsel] = '0;
                                    pend_eol_next  = 1'b1;
                                end
                                else
                                begin
                                    cur_next[gsel]    = pos;
                                    mem_re            = 1'b1;
                                    mem_raddr         = base + ADDR_W'(pos);
                                    pend_present_next = (CNT_W'(pos) < fill);
                                end
                            end
                        end
                    endcase
                end
            end
            rgct_pkg::ST_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    state_next       = rgct_pkg::ST_IDLE;
                    out_valid_next   = 1'b1;
                    out_status_next  = pend_status_reg;
                    out_present_next = pend_present_reg;
                    out_id_next      = pend_present_reg ? mem_rdata : '0;
                    out_eol_next     = pend_eol_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rgct_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int g = 0; g < GROUPS; g++)
            begin
                cnt_reg[g] <= '0;
                cur_reg[g] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            cur_reg       <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_status_reg  <= pend_status_next;
        pend_present_reg <= pend_present_next;
        pend_eol_reg     <= pend_eol_next;
        out_status_reg   <= out_status_next;
        out_present_reg  <= out_present_next;
        out_id_reg       <= out_id_next;
        out_eol_reg      <= out_eol_next;
    end

endmodule

@@ rtl/rgct_checker.sv @@
`include "rate_group_client_table_core_assert.svh"

module rgct_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic                      rsp_status,
    input logic                      rsp_entry_present,
    input logic [rgct_pkg::ID_W-1:0] rsp_entry_id,
    input logic                      rsp_end_of_list
);

    // a result waiting for its sink stays valid and keeps its entry id
    `RGCT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_id))

    // one request in flight at a time
    `RGCT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // an empty slot reads as zero
    `RGCT_ASSERT_SAME(a_empty_zero, rsp_valid && !rsp_entry_present, rsp_entry_id == '0)

    // full flag and end of list never come with an entry, nor with each other
    `RGCT_ASSERT_SAME(a_flags_excl, rsp_valid && (rsp_status || rsp_end_of_list),
                      !rsp_entry_present && !(rsp_status && rsp_end_of_list))

endmodule

bind rate_group_client_table_core rgct_checker u_rgct_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_entry_present (rsp.entry_present),
    .rsp_entry_id      (rsp.entry_id),
    .rsp_end_of_list   (rsp.end_of_list)
);
